>>> hdl/bort_pkg.sv
// Package for the buffer ownership range tracker.
// Holds sizes, operation and status codes, and the chunk word type.
// No dependencies.
`default_nettype none
package bort_pkg;

  localparam int MAX_REGIONS = 8;
  localparam int MAX_CHUNKS  = 16;
  localparam int OFFSET_BITS = 32;

  localparam int RIDX_W  = $clog2(MAX_REGIONS);
  localparam int CIDX_W  = $clog2(MAX_CHUNKS);
  localparam int CCNT_W  = CIDX_W + 1;
  localparam int MADDR_W = RIDX_W + CIDX_W;
  localparam int MDEPTH  = MAX_REGIONS * MAX_CHUNKS;

  typedef enum logic [1:0] {
    MODE_REG   = 2'd0,
    MODE_DEREG = 2'd1,
    MODE_ENQ   = 2'd2,
    MODE_DEQ   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNKNOWN    = 3'd1,
    ST_NONE_FREE  = 3'd2,
    ST_BAD_RANGE  = 3'd3,
    ST_NOT_IN_USE = 3'd4,
    ST_BUSY       = 3'd5,
    ST_FULL       = 3'd6,
    ST_RSVD       = 3'd7
  } status_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] size;
  } chunk_t;

endpackage
`default_nettype wire

>>> hdl/buffer_ownership_range_tracker_unit.sv
// Top level of the buffer ownership range tracker.
// Region table, chunk memory and the operation sequencer; uses bort_pkg.
//
// Each operation takes one transfer in and gives one status transfer out. The block
// handles one operation at a time: the region table is scanned one slot per cycle,
// then for enqueue and dequeue the region's sorted chunk list is walked in the chunk
// memory one chunk at a time (one read port with registered data), and a chunk
// removal or insertion shifts the following entries one at a time.
`default_nettype none
module buffer_ownership_range_tracker_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_region_id,
  input  wire logic [31:0] in_range_start,
  input  wire logic [31:0] in_range_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic             out_region_added
);
  import bort_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SCAN   = 11'b00000000010,
    S_DECIDE = 11'b00000000100,
    S_RD     = 11'b00000001000,
    S_EV     = 11'b00000010000,
    S_DQDEC  = 11'b00000100000,
    S_SHRD   = 11'b00001000000,
    S_SHWR   = 11'b00010000000,
    S_OPWR   = 11'b00100000000,
    S_FIN    = 11'b01000000000,
    S_SPARE  = 11'b10000000000
  } state_t;

  state_t                 state_r;
  mode_t                  mode_r;
  logic [31:0]            key_r;
  logic [OFFSET_BITS-1:0] s_r;
  logic [OFFSET_BITS-1:0] l_r;
  logic [OFFSET_BITS:0]   e_r;

  logic                   rvalid_r [MAX_REGIONS];
  logic [31:0]            rkey_r   [MAX_REGIONS];
  logic [OFFSET_BITS-1:0] rsize_r  [MAX_REGIONS];
  logic                   rinf_r   [MAX_REGIONS];
  logic [CCNT_W-1:0]      ccnt_r   [MAX_REGIONS];

  logic [RIDX_W-1:0]      scan_r;
  logic                   found_r;
  logic [RIDX_W-1:0]      slot_r;
  logic                   have_free_r;
  logic [RIDX_W-1:0]      free_r;

  logic [CCNT_W-1:0]      idx_r;
  logic [CCNT_W-1:0]      n_r;
  logic                   have_prev_r;
  chunk_t                 prev_r;
  logic                   cur_ok_r;
  chunk_t                 cur_r;
  chunk_t                 pend_r;
  logic [CCNT_W-1:0]      pend_idx_r;
  logic                   dir_up_r;
  logic [CCNT_W-1:0]      sh_j_r;

  status_t                status_r;
  logic                   added_r;
  logic                   out_valid_r;
  status_t                out_status_r;
  logic                   out_added_r;

  chunk_t                 mem_r [MDEPTH];
  chunk_t                 rdata_r;
  logic [MADDR_W-1:0]     raddr;
  logic                   wr_en_r;
  logic [MADDR_W-1:0]     wr_addr_r;
  chunk_t                 wr_data_r;

  logic [CCNT_W-1:0]      sh_src;
  logic [OFFSET_BITS:0]   ce;
  logic [OFFSET_BITS:0]   pe;
  logic                   bad;

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_region_added = out_added_r;

  assign sh_src = dir_up_r ? (sh_j_r - CCNT_W'(1)) : (sh_j_r + CCNT_W'(1));
  assign raddr  = (state_r == S_RD) ? {slot_r, idx_r[CIDX_W-1:0]}
                                    : {slot_r, sh_src[CIDX_W-1:0]};
  assign ce  = {1'b0, rdata_r.start} + {1'b0, rdata_r.size};
  assign pe  = {1'b0, prev_r.start} + {1'b0, prev_r.size};
  assign bad = (l_r == '0) || e_r[OFFSET_BITS];

  always_ff @(posedge clk) begin
    if (wr_en_r) begin
      mem_r[wr_addr_r] <= wr_data_r;
    end
    rdata_r <= mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wr_en_r     <= 1'b0;
      for (int i = 0; i < MAX_REGIONS; i++) begin
        rvalid_r[i] <= 1'b0;
        ccnt_r[i]   <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          wr_en_r <= 1'b0;
          if (in_valid) begin
            mode_r      <= mode_t'(in_mode);
            key_r       <= in_region_id;
            s_r         <= in_range_start;
            l_r         <= in_range_size;
            e_r         <= {1'b0, in_range_start} + {1'b0, in_range_size};
            scan_r      <= '0;
            found_r     <= 1'b0;
            have_free_r <= 1'b0;
            added_r     <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          wr_en_r <= 1'b0;
          if (rvalid_r[scan_r] && rkey_r[scan_r] == key_r && !found_r) begin
            found_r <= 1'b1;
            slot_r  <= scan_r;
          end
          if (!rvalid_r[scan_r] && !have_free_r) begin
            have_free_r <= 1'b1;
            free_r      <= scan_r;
          end
          if (scan_r == RIDX_W'(MAX_REGIONS - 1)) begin
            state_r <= S_DECIDE;
          end
          scan_r <= scan_r + RIDX_W'(1);
        end
        S_DECIDE: begin
          idx_r       <= '0;
          n_r         <= ccnt_r[slot_r];
          have_prev_r <= 1'b0;
          unique case (mode_r)
            MODE_REG: begin
              state_r   <= S_FIN;
              wr_en_r   <= (l_r != '0) && !found_r && have_free_r;
              wr_addr_r <= {free_r, CIDX_W'(0)};
              wr_data_r <= '{start: '0, size: l_r};
              if (l_r == '0) begin
                status_r <= ST_BAD_RANGE;
              end else if (found_r) begin
                status_r <= ST_BUSY;
              end else if (!have_free_r) begin
                status_r <= ST_FULL;
              end else begin
                status_r         <= ST_OK;
                rvalid_r[free_r] <= 1'b1;
                rkey_r[free_r]   <= key_r;
                rsize_r[free_r]  <= l_r;
                rinf_r[free_r]   <= 1'b0;
                ccnt_r[free_r]   <= CCNT_W'(1);
              end
            end
            MODE_DEREG: begin
              wr_en_r <= 1'b0;
              if (!found_r) begin
                status_r <= ST_UNKNOWN;
                state_r  <= S_FIN;
              end else if (ccnt_r[slot_r] != CCNT_W'(1)) begin
                status_r <= ST_BUSY;
                state_r  <= S_FIN;
              end else begin
                status_r <= ST_OK;
                state_r  <= S_RD;
              end
            end
            MODE_ENQ: begin
              wr_en_r <= 1'b0;
              if (bad) begin
                status_r <= ST_BAD_RANGE;
                state_r  <= S_FIN;
              end else if (!found_r) begin
                status_r <= ST_UNKNOWN;
                state_r  <= S_FIN;
              end else if (ccnt_r[slot_r] == '0) begin
                status_r <= ST_NONE_FREE;
                state_r  <= S_FIN;
              end else begin
                status_r <= ST_OK;
                state_r  <= S_RD;
              end
            end
            MODE_DEQ: begin
              wr_en_r   <= !bad && !found_r && have_free_r;
              wr_addr_r <= {free_r, CIDX_W'(0)};
              wr_data_r <= '{start: '0, size: e_r[OFFSET_BITS-1:0]};
              if (bad) begin
                status_r <= ST_BAD_RANGE;
                state_r  <= S_FIN;
              end else if (found_r) begin
                if (e_r > {1'b0, rsize_r[slot_r]}) begin
                  if (rinf_r[slot_r]) begin
                    rsize_r[slot_r] <= e_r[OFFSET_BITS-1:0];
                    status_r        <= ST_OK;
                    state_r         <= S_RD;
                  end else begin
                    status_r <= ST_BAD_RANGE;
                    state_r  <= S_FIN;
                  end
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_RD;
                end
              end else if (!have_free_r) begin
                status_r <= ST_FULL;
                state_r  <= S_FIN;
              end else begin
                status_r         <= ST_OK;
                state_r          <= S_FIN;
                rvalid_r[free_r] <= 1'b1;
                rkey_r[free_r]   <= key_r;
                rsize_r[free_r]  <= e_r[OFFSET_BITS-1:0];
                rinf_r[free_r]   <= 1'b1;
                ccnt_r[free_r]   <= CCNT_W'(1);
                added_r          <= 1'b1;
              end
            end
            default: begin
              wr_en_r  <= 1'b0;
              status_r <= ST_OK;
              state_r  <= S_FIN;
            end
          endcase
        end
        S_RD: begin
          wr_en_r <= 1'b0;
          if (mode_r == MODE_DEREG) begin
            state_r <= S_EV;
          end else if (idx_r == n_r) begin
            if (mode_r == MODE_ENQ) begin
              status_r <= ST_BAD_RANGE;
              state_r  <= S_FIN;
            end else begin
              cur_ok_r <= 1'b0;
              state_r  <= S_DQDEC;
            end
          end else begin
            state_r <= S_EV;
          end
        end
        S_EV: begin
          if (mode_r == MODE_DEREG) begin
            wr_en_r <= 1'b0;
            state_r <= S_FIN;
            if (rdata_r.start == '0 && rdata_r.size == rsize_r[slot_r]) begin
              rvalid_r[slot_r] <= 1'b0;
              ccnt_r[slot_r]   <= '0;
            end else begin
              status_r <= ST_BUSY;
            end
          end else if (mode_r == MODE_ENQ) begin
            if (s_r < rdata_r.start || e_r > ce) begin
              wr_en_r <= 1'b0;
              idx_r   <= idx_r + CCNT_W'(1);
              state_r <= S_RD;
            end else if (rdata_r.start == s_r) begin
              if (ce == e_r) begin
                wr_en_r  <= 1'b0;
                sh_j_r   <= idx_r;
                dir_up_r <= 1'b0;
                state_r  <= S_SHRD;
              end else begin
                wr_en_r   <= 1'b1;
                wr_addr_r <= {slot_r, idx_r[CIDX_W-1:0]};
                wr_data_r <= '{start: e_r[OFFSET_BITS-1:0],
                               size: ce[OFFSET_BITS-1:0] - e_r[OFFSET_BITS-1:0]};
                state_r   <= S_FIN;
              end
            end else if (ce == e_r) begin
              wr_en_r   <= 1'b1;
              wr_addr_r <= {slot_r, idx_r[CIDX_W-1:0]};
              wr_data_r <= '{start: rdata_r.start, size: s_r - rdata_r.start};
              state_r   <= S_FIN;
            end else if (n_r == CCNT_W'(MAX_CHUNKS)) begin
              wr_en_r  <= 1'b0;
              status_r <= ST_FULL;
              state_r  <= S_FIN;
            end else begin
              wr_en_r    <= 1'b1;
              wr_addr_r  <= {slot_r, idx_r[CIDX_W-1:0]};
              wr_data_r  <= '{start: rdata_r.start, size: s_r - rdata_r.start};
              pend_r     <= '{start: e_r[OFFSET_BITS-1:0],
                              size: ce[OFFSET_BITS-1:0] - e_r[OFFSET_BITS-1:0]};
              pend_idx_r <= idx_r + CCNT_W'(1);
              sh_j_r     <= n_r;
              dir_up_r   <= 1'b1;
              state_r    <= S_SHRD;
            end
          end else begin
            wr_en_r <= 1'b0;
            if (rdata_r.start < s_r) begin
              prev_r      <= rdata_r;
              have_prev_r <= 1'b1;
              idx_r       <= idx_r + CCNT_W'(1);
              state_r     <= S_RD;
            end else begin
              cur_r    <= rdata_r;
              cur_ok_r <= 1'b1;
              state_r  <= S_DQDEC;
            end
          end
        end
        S_DQDEC: begin
          if (have_prev_r && pe > {1'b0, s_r}) begin
            wr_en_r  <= 1'b0;
            status_r <= ST_NOT_IN_USE;
            state_r  <= S_FIN;
          end else if (cur_ok_r && {1'b0, cur_r.start} < e_r) begin
            wr_en_r  <= 1'b0;
            status_r <= ST_NOT_IN_USE;
            state_r  <= S_FIN;
          end else if (have_prev_r && pe == {1'b0, s_r}) begin
            wr_en_r   <= 1'b1;
            wr_addr_r <= {slot_r, idx_r[CIDX_W-1:0] - CIDX_W'(1)};
            if (cur_ok_r && {1'b0, cur_r.start} == e_r) begin
              wr_data_r <= '{start: prev_r.start, size: prev_r.size + l_r + cur_r.size};
              sh_j_r    <= idx_r;
              dir_up_r  <= 1'b0;
              state_r   <= S_SHRD;
            end else begin
              wr_data_r <= '{start: prev_r.start, size: prev_r.size + l_r};
              state_r   <= S_FIN;
            end
          end else if (cur_ok_r && {1'b0, cur_r.start} == e_r) begin
            wr_en_r   <= 1'b1;
            wr_addr_r <= {slot_r, idx_r[CIDX_W-1:0]};
            wr_data_r <= '{start: s_r, size: cur_r.size + l_r};
            state_r   <= S_FIN;
          end else if (n_r == CCNT_W'(MAX_CHUNKS)) begin
            wr_en_r  <= 1'b0;
            status_r <= ST_FULL;
            state_r  <= S_FIN;
          end else begin
            wr_en_r    <= 1'b0;
            pend_r     <= '{start: s_r, size: l_r};
            pend_idx_r <= idx_r;
            sh_j_r     <= n_r;
            dir_up_r   <= 1'b1;
            state_r    <= S_SHRD;
          end
        end
        S_SHRD: begin
          wr_en_r <= 1'b0;
          if (dir_up_r) begin
            state_r <= (sh_j_r == pend_idx_r) ? S_OPWR : S_SHWR;
          end else if (sh_src >= n_r) begin
            ccnt_r[slot_r] <= n_r - CCNT_W'(1);
            state_r        <= S_FIN;
          end else begin
            state_r <= S_SHWR;
          end
        end
        S_SHWR: begin
          wr_en_r   <= 1'b1;
          wr_addr_r <= {slot_r, sh_j_r[CIDX_W-1:0]};
          wr_data_r <= rdata_r;
          sh_j_r    <= sh_src;
          state_r   <= S_SHRD;
        end
        S_OPWR: begin
          wr_en_r        <= 1'b1;
          wr_addr_r      <= {slot_r, pend_idx_r[CIDX_W-1:0]};
          wr_data_r      <= pend_r;
          ccnt_r[slot_r] <= n_r + CCNT_W'(1);
          state_r        <= S_FIN;
        end
        S_FIN: begin
          wr_en_r <= 1'b0;
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_added_r  <= added_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          wr_en_r <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
